/* rtl/cism_pkg.sv */
`timescale 1ns / 1ps

package cism_pkg;

	localparam int TEXT_W     = 8;
	localparam int MS_W       = 16;
	localparam int CFG_W      = 64;
	localparam int CFG_IDX_W  = 2;
	localparam int LENREG_W   = 5;
	localparam int PAT_BYTES  = 16;

	localparam logic [TEXT_W-1:0] FOLD_MASK = 8'hDF;
	localparam logic [TEXT_W-1:0] UPPER_LO  = 8'h41;
	localparam logic [TEXT_W-1:0] UPPER_HI  = 8'h5A;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PAT_LOW  = 2'd0,
		REG_PAT_HIGH = 2'd1,
		REG_PAT_LEN  = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [TEXT_W-1:0] text_byte;
		logic              last_byte;
	} in_word_t;

	typedef struct packed {
		logic            found;
		logic [MS_W-1:0] match_start;
		logic            position_overflow;
	} out_word_t;

	function automatic logic bytes_match(input logic [TEXT_W-1:0] t,
			input logic [TEXT_W-1:0] p);
		logic [TEXT_W-1:0] ft;
		logic [TEXT_W-1:0] fp;
		logic              letter;
		ft = t & FOLD_MASK;
		fp = p & FOLD_MASK;
		letter = (ft >= UPPER_LO) && (ft <= UPPER_HI);
		return (ft == fp) && (letter || (t == p));
	endfunction

endpackage

/* rtl/cism_cell.sv */
`timescale 1ns / 1ps

module cism_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       advance,
	input  logic                       clear,
	input  logic                       enable,
	input  logic [cism_pkg::TEXT_W-1:0] text_byte,
	input  logic [cism_pkg::TEXT_W-1:0] pat_byte,
	input  logic                       prev,
	output logic                       hit,
	output logic                       prefix
);
	import cism_pkg::*;

	logic prefix_q;

	assign hit    = enable && prev && bytes_match(text_byte, pat_byte);
	assign prefix = prefix_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q <= 1'b0;
		end else if (advance) begin
			prefix_q <= clear ? 1'b0 : hit;
		end
	end

endmodule

/* rtl/case_insensitive_substring_match_core.sv */
`timescale 1ns / 1ps
// channel | signals                        | word
// in      | in_valid / in_ready / in_word   | text_byte, last_byte
// out     | out_valid / out_ready / out_word| found, match_start, position_overflow
// cfg     | cfg_we / cfg_index / cfg_data   | pattern_low/high_bytes, pattern_length
// One byte per cycle unless stalled; the result leaves the cycle after the last byte.
// The cell row compares every pattern position against the byte in the same cycle.
// Reset clears the pattern, the cell row, the position tracker and the output register.
// A stalled result holds only last bytes back; other bytes keep streaming.

module case_insensitive_substring_match_core #(
	parameter int PATTERN_MAX   = 16,
	parameter int POSITION_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  cism_pkg::in_word_t            in_word,
	output logic                          out_valid,
	input  logic                          out_ready,
	output cism_pkg::out_word_t           out_word,
	input  logic                          cfg_we,
	input  logic [cism_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cism_pkg::CFG_W-1:0]     cfg_data
);
	import cism_pkg::*;

	localparam int LEN_W = $clog2(PATTERN_MAX + 1);
	localparam int LW    = (LEN_W > LENREG_W) ? LEN_W : LENREG_W;
	localparam int IW    = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
	localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

	logic [2*CFG_W-1:0]     pat_q;
	logic [LENREG_W-1:0]    len_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic [POSITION_BITS-1:0] start_q;
	logic                   match_q;
	logic                   ovf_q;
	logic                   out_valid_q;
	out_word_t              out_word_q;

	logic                   accept;
	logic                   last;
	logic [LW-1:0]          len_cmp;
	logic [LW-1:0]          len_eff;
	logic [LW-1:0]          len_m1;
	logic [PATTERN_MAX-1:0] hit;
	logic [PATTERN_MAX-1:0] prefix;
	logic                   new_match;
	logic [POSITION_BITS-1:0] new_start;
	logic [POSITION_BITS-1:0] len_ext;
	logic                   at_max;
	logic                   found_now;
	logic [POSITION_BITS-1:0] start_now;

	assign last     = in_word.last_byte;
	assign in_ready = !out_valid_q || out_ready || !last;
	assign accept   = in_valid && in_ready;

	assign len_cmp = LW'(len_q);
	assign len_eff = (len_cmp > LW'(PATTERN_MAX)) ? LW'(PATTERN_MAX) : len_cmp;
	assign len_m1  = len_eff - LW'(1);
	assign len_ext = POSITION_BITS'(len_m1);

	genvar gi;
	generate
		for (gi = 0; gi < PATTERN_MAX; gi++) begin : g_cell
			logic [TEXT_W-1:0] pbyte;
			logic              prev;
			if (gi < PAT_BYTES) begin : g_pat
				assign pbyte = pat_q[gi*TEXT_W +: TEXT_W];
			end else begin : g_zero
				assign pbyte = '0;
			end
			if (gi == 0) begin : g_head
				assign prev = 1'b1;
			end else begin : g_link
				assign prev = prefix[gi-1];
			end
			cism_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.advance  (accept),
				.clear    (last),
				.enable   (LW'(gi) < len_eff),
				.text_byte(in_word.text_byte),
				.pat_byte (pbyte),
				.prev     (prev),
				.hit      (hit[gi]),
				.prefix   (prefix[gi])
			);
		end
	endgenerate

	assign new_match = (len_eff == '0) || hit[len_m1[IW-1:0]];
	assign new_start = (len_eff == '0) ? '0 :
		((pos_q >= len_ext) ? (pos_q - len_ext) : '0);
	assign at_max    = (pos_q == POS_MAX);
	assign found_now = match_q || new_match;
	assign start_now = match_q ? start_q : new_start;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q <= '0;
			len_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PAT_LOW:  pat_q[CFG_W-1:0]       <= cfg_data;
				REG_PAT_HIGH: pat_q[2*CFG_W-1:CFG_W] <= cfg_data;
				REG_PAT_LEN:  len_q                  <= cfg_data[LENREG_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			start_q <= '0;
			match_q <= 1'b0;
			ovf_q   <= 1'b0;
		end else if (accept) begin
			if (last) begin
				pos_q   <= '0;
				start_q <= '0;
				match_q <= 1'b0;
				ovf_q   <= 1'b0;
			end else begin
				pos_q   <= at_max ? pos_q : pos_q + POSITION_BITS'(1);
				ovf_q   <= ovf_q || at_max;
				match_q <= found_now;
				start_q <= start_now;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_word_q <= '0;
		end else if (accept && last) begin
			out_word_q.found             <= found_now;
			out_word_q.match_start       <= found_now ? MS_W'(start_now) : '0;
			out_word_q.position_overflow <= ovf_q || at_max;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule

/* rtl/cism_checker.sv */
`timescale 1ns / 1ps

module cism_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input cism_pkg::in_word_t  in_word,
	input logic                out_valid,
	input logic                out_ready,
	input cism_pkg::out_word_t out_word
);
	import cism_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word))
		else $error("result word changed while stalled");

	a_last_gives_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_word.last_byte |=> out_valid)
		else $error("last byte gave no result word");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !in_word.last_byte && !(out_valid && !out_ready)
		|=> !out_valid)
		else $error("result word without a last byte");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_word.found |-> out_word.match_start == '0)
		else $error("match_start nonzero on a miss");

endmodule

bind case_insensitive_substring_match_core cism_checker u_cism_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.in_word  (in_word),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_word (out_word)
);
